/* rtl/core/nav_state_frame_serializer_macros.svh */
// assertion macros shared by the serializer checker
`ifndef NAV_STATE_FRAME_SERIALIZER_MACROS_SVH
`define NAV_STATE_FRAME_SERIALIZER_MACROS_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define NSFS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define NSFS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/nsfs_pkg.sv */
// types, constants and byte map of the navigation state frame serializer
package nsfs_pkg;

  // record and frame geometry
  localparam int NUM_FIELDS = 12;
  localparam int NUM_WIDE   = 6;
  localparam int FRAME_LEN  = 35;
  localparam int FIELD_BASE = 4;
  localparam int BIDX_W     = 6;
  localparam int FIDX_W     = 4;
  localparam int APB_ADDR_W = 5;

  localparam logic [BIDX_W-1:0] BYTE_HDR  = BIDX_W'(0);
  localparam logic [BIDX_W-1:0] BYTE_CMD  = BIDX_W'(1);
  localparam logic [BIDX_W-1:0] BYTE_LEN  = BIDX_W'(2);
  localparam logic [BIDX_W-1:0] BYTE_MODE = BIDX_W'(3);
  localparam logic [BIDX_W-1:0] LAST_IDX  = BIDX_W'(FRAME_LEN - 1);
  localparam logic [FIDX_W-1:0] LAST_FLD  = FIDX_W'(NUM_FIELDS - 1);

  // first field of each group
  localparam logic [FIDX_W-1:0] FLD_VEL0  = FIDX_W'(3);
  localparam logic [FIDX_W-1:0] FLD_ANG0  = FIDX_W'(6);
  localparam logic [FIDX_W-1:0] FLD_RATE0 = FIDX_W'(9);

  // frame constants
  localparam logic [7:0] HDR_BYTE     = 8'h91;
  localparam logic [7:0] CMD_BYTE     = 8'h55;
  localparam logic [7:0] LEN_BYTE     = 8'h1F;
  localparam logic [7:0] MODE_ORBIT   = 8'h3C;
  localparam logic [7:0] MODE_REENTRY = 8'hC3;

  // rounding and saturation
  localparam logic [63:0] ROUND_HALF = 64'h0000_0000_8000_0000;
  localparam logic [31:0] SAT_WIDE   = 32'h007F_FFFF;
  localparam logic [31:0] SAT_NARROW = 32'h0000_7FFF;

  // register map
  typedef enum logic [2:0] {
    REG_ON_TRACK    = 3'd0,
    REG_POS_RECIP   = 3'd1,
    REG_VEL_RECIP   = 3'd2,
    REG_ANG_ORBIT   = 3'd3,
    REG_ANG_REENTRY = 3'd4,
    REG_RATE_ORBIT  = 3'd5,
    REG_RATE_REENTRY = 3'd6
  } reg_idx_e;

  localparam logic        RST_ON_TRACK     = 1'b1;
  localparam logic [31:0] RST_POS_RECIP    = 32'd65536000;
  localparam logic [31:0] RST_VEL_RECIP    = 32'd43690667;
  localparam logic [31:0] RST_ANG_ORBIT    = 32'd2560000;
  localparam logic [31:0] RST_ANG_REENTRY  = 32'd10922667;
  localparam logic [31:0] RST_RATE_ORBIT   = 32'd12800000;
  localparam logic [31:0] RST_RATE_REENTRY = 32'd18724571;

  typedef struct packed {
    logic        on_track;
    logic [31:0] pos_recip;
    logic [31:0] vel_recip;
    logic [31:0] ang_orbit;
    logic [31:0] ang_reentry;
    logic [31:0] rate_orbit;
    logic [31:0] rate_reentry;
  } cfg_t;

  // where a frame byte comes from
  typedef enum logic [1:0] {
    SRC_CONST = 2'd0,
    SRC_MODE  = 2'd1,
    SRC_FIELD = 2'd2,
    SRC_CHECK = 2'd3
  } src_e;

  typedef struct packed {
    src_e              kind;
    logic [7:0]        cval;
    logic [FIDX_W-1:0] fld;
    logic [1:0]        lane;
  } byte_sel_t;

  // controller to datapath
  typedef struct packed {
    logic              capture;
    logic              load;
    logic [BIDX_W-1:0] byte_idx;
    logic              comp_en;
    logic [FIDX_W-1:0] comp_idx;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_space;
  } dp_status_t;

  // map a frame position to its source; lane 0 is bits 23:16 of a field word
  function automatic byte_sel_t byte_sel(logic [BIDX_W-1:0] idx);
    byte_sel_t s;
    int        start;
    int        len;
    s.kind = SRC_CONST;
    s.cval = HDR_BYTE;
    s.fld  = '0;
    s.lane = '0;
    case (idx)
      BYTE_HDR:  s.cval = HDR_BYTE;
      BYTE_CMD:  s.cval = CMD_BYTE;
      BYTE_LEN:  s.cval = LEN_BYTE;
      BYTE_MODE: s.kind = SRC_MODE;
      LAST_IDX:  s.kind = SRC_CHECK;
      default: ;
    endcase
    for (int f = 0; f < NUM_FIELDS; f++) begin
      start = (f < NUM_WIDE) ? FIELD_BASE + 3 * f
                             : FIELD_BASE + 3 * NUM_WIDE + 2 * (f - NUM_WIDE);
      len   = (f < NUM_WIDE) ? 3 : 2;
      for (int b = 0; b < 3; b++) begin
        if (b < len && idx == BIDX_W'(start + b)) begin
          s.kind = SRC_FIELD;
          s.fld  = FIDX_W'(f);
          s.lane = 2'(b + 3 - len);
        end
      end
    end
    return s;
  endfunction

endpackage

/* rtl/core/nsfs_intf.sv */
// record and frame byte channels of the serializer

// navigation record channel
interface nsfs_rec_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic signed [31:0] angle_one;
  logic signed [31:0] angle_two;
  logic signed [31:0] angle_three;
  logic signed [31:0] rate_one;
  logic signed [31:0] rate_two;
  logic signed [31:0] rate_three;

  modport source (
    output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
           angle_one, angle_two, angle_three, rate_one, rate_two, rate_three,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
           angle_one, angle_two, angle_three, rate_one, rate_two, rate_three,
    output ready
  );
endinterface

// frame byte channel
interface nsfs_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink (input valid, frame_byte, last_byte, output ready);
endinterface

/* rtl/core/nsfs_regs.sv */
// apb configuration registers of the serializer
module nsfs_regs import nsfs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[APB_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register write decode, unmapped addresses are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_ON_TRACK:     cfg_d.on_track     = pwdata[0];
        REG_POS_RECIP:    cfg_d.pos_recip    = pwdata;
        REG_VEL_RECIP:    cfg_d.vel_recip    = pwdata;
        REG_ANG_ORBIT:    cfg_d.ang_orbit    = pwdata;
        REG_ANG_REENTRY:  cfg_d.ang_reentry  = pwdata;
        REG_RATE_ORBIT:   cfg_d.rate_orbit   = pwdata;
        REG_RATE_REENTRY: cfg_d.rate_reentry = pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.on_track     <= RST_ON_TRACK;
      cfg_q.pos_recip    <= RST_POS_RECIP;
      cfg_q.vel_recip    <= RST_VEL_RECIP;
      cfg_q.ang_orbit    <= RST_ANG_ORBIT;
      cfg_q.ang_reentry  <= RST_ANG_REENTRY;
      cfg_q.rate_orbit   <= RST_RATE_ORBIT;
      cfg_q.rate_reentry <= RST_RATE_REENTRY;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_ON_TRACK:     prdata = {31'd0, cfg_q.on_track};
      REG_POS_RECIP:    prdata = cfg_q.pos_recip;
      REG_VEL_RECIP:    prdata = cfg_q.vel_recip;
      REG_ANG_ORBIT:    prdata = cfg_q.ang_orbit;
      REG_ANG_REENTRY:  prdata = cfg_q.ang_reentry;
      REG_RATE_ORBIT:   prdata = cfg_q.rate_orbit;
      REG_RATE_REENTRY: prdata = cfg_q.rate_reentry;
      default:          prdata = '0;
    endcase
  end

endmodule

/* rtl/core/nsfs_ctrl.sv */
// serializer controller: record handshake, byte sequencing, field scaling order
module nsfs_ctrl import nsfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t sts_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } ctrl_state_e;

  ctrl_state_e       state_q, state_d;
  logic [BIDX_W-1:0] byte_q, byte_d;
  logic              comp_act_q, comp_act_d;
  logic [FIDX_W-1:0] comp_q, comp_d;
  logic              load;
  logic              last_load;
  logic              accept;

  // a new request is taken while idle or as the checksum byte goes out
  assign load       = (state_q == ST_EMIT) && sts_i.out_space;
  assign last_load  = load && (byte_q == LAST_IDX);
  assign in_ready_o = (state_q == ST_IDLE) || last_load;
  assign accept     = in_valid_i && in_ready_o;

  // frame sequencing
  always_comb begin
    state_d = state_q;
    byte_d  = byte_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EMIT;
          byte_d  = '0;
        end
      end
      ST_EMIT: begin
        if (load) begin
          if (byte_q == LAST_IDX) begin
            state_d = accept ? ST_EMIT : ST_IDLE;
            byte_d  = '0;
          end else begin
            byte_d = byte_q + BIDX_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
        byte_d  = '0;
      end
    endcase
  end

  // one field through the scaler per cycle after a request is taken
  always_comb begin
    comp_act_d = comp_act_q;
    comp_d     = comp_q;
    if (accept) begin
      comp_act_d = 1'b1;
      comp_d     = '0;
    end else if (comp_act_q) begin
      if (comp_q == LAST_FLD) begin
        comp_act_d = 1'b0;
      end else begin
        comp_d = comp_q + FIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      byte_q     <= '0;
      comp_act_q <= 1'b0;
      comp_q     <= '0;
    end else begin
      state_q    <= state_d;
      byte_q     <= byte_d;
      comp_act_q <= comp_act_d;
      comp_q     <= comp_d;
    end
  end

  assign cmd_o.capture  = accept;
  assign cmd_o.load     = load;
  assign cmd_o.byte_idx = byte_q;
  assign cmd_o.comp_en  = comp_act_q;
  assign cmd_o.comp_idx = comp_q;

endmodule

/* rtl/core/nsfs_dp.sv */
// serializer datapath: record store, scaler, field store, checksum, output register
module nsfs_dp import nsfs_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cfg_t                         cfg_i,
  input  ctrl_cmd_t                    cmd_i,
  output dp_status_t                   sts_o,
  input  logic [NUM_FIELDS-1:0][31:0]  rec_vals_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   frame_byte_o,
  output logic                         last_byte_o
);

  logic [NUM_FIELDS-1:0][31:0] vals_q;
  logic [31:0]                 cur;
  logic                        cur_neg;
  logic [31:0]                 cur_mag;
  logic [31:0]                 recip;
  logic [63:0]                 prod_q;
  logic                        p_neg_q;
  logic [FIDX_W-1:0]           p_idx_q;
  logic                        p_vld_q;
  logic [63:0]                 rnd;
  logic [31:0]                 n_full;
  logic                        wide;
  logic [31:0]                 limit;
  logic [31:0]                 n_sat;
  logic [23:0]                 word;
  logic [23:0]                 fld_q [NUM_FIELDS];
  byte_sel_t                   sel;
  logic [23:0]                 sel_word;
  logic [7:0]                  byte_val;
  logic [7:0]                  chk_q, chk_d;
  logic                        out_valid_q;
  logic [7:0]                  out_byte_q;
  logic                        out_last_q;

  // record store
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      vals_q <= rec_vals_i;
    end
  end

  // scaler stage one: magnitude and scale select, then the multiply
  assign cur     = vals_q[cmd_i.comp_idx];
  assign cur_neg = cur[31];
  assign cur_mag = cur_neg ? (~cur + 32'd1) : cur;

  always_comb begin
    case (cmd_i.comp_idx) inside
      [4'd0 : FLD_VEL0 - 4'd1]:  recip = cfg_i.pos_recip;
      [FLD_VEL0 : FLD_ANG0 - 4'd1]:
        recip = cfg_i.vel_recip;
      [FLD_ANG0 : FLD_RATE0 - 4'd1]:
        recip = cfg_i.on_track ? cfg_i.ang_orbit : cfg_i.ang_reentry;
      default: recip = cfg_i.on_track ? cfg_i.rate_orbit : cfg_i.rate_reentry;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.comp_en) begin
      prod_q  <= {32'd0, cur_mag} * {32'd0, recip};
      p_neg_q <= cur_neg;
      p_idx_q <= cmd_i.comp_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= cmd_i.comp_en;
    end
  end

  // scaler stage two: round half up, saturate, fold in the sign
  assign rnd    = prod_q + ROUND_HALF;
  assign n_full = rnd[63:32];
  assign wide   = (p_idx_q < FIDX_W'(NUM_WIDE));
  assign limit  = wide ? SAT_WIDE : SAT_NARROW;
  assign n_sat  = (n_full > limit) ? limit : n_full;
  assign word   = wide ? {p_neg_q, n_sat[22:0]} : {8'd0, p_neg_q, n_sat[14:0]};

  always_ff @(posedge clk_i) begin
    if (p_vld_q) begin
      fld_q[p_idx_q] <= word;
    end
  end

  // frame byte select
  assign sel      = byte_sel(cmd_i.byte_idx);
  assign sel_word = fld_q[sel.fld];

  always_comb begin
    case (sel.kind)
      SRC_CONST: byte_val = sel.cval;
      SRC_MODE:  byte_val = cfg_i.on_track ? MODE_ORBIT : MODE_REENTRY;
      SRC_FIELD: begin
        case (sel.lane)
          2'd0:    byte_val = sel_word[23:16];
          2'd1:    byte_val = sel_word[15:8];
          default: byte_val = sel_word[7:0];
        endcase
      end
      default:   byte_val = chk_q;
    endcase
  end

  // checksum over the mode byte and the fields, cleared as it goes out
  always_comb begin
    chk_d = chk_q;
    if (cmd_i.load) begin
      case (sel.kind)
        SRC_CHECK: chk_d = '0;
        SRC_CONST: chk_d = chk_q;
        default:   chk_d = chk_q ^ byte_val;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      chk_q <= chk_d;
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_byte_q <= byte_val;
      out_last_q <= (sel.kind == SRC_CHECK);
    end
  end

  assign sts_o.out_space = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign frame_byte_o    = out_byte_q;
  assign last_byte_o     = out_last_q;

endmodule

/* rtl/core/nav_state_frame_serializer.sv */
// top level of the navigation state frame serializer
//
// rec_i takes one navigation record (twelve signed Q15.16 values) per request.
// frame_o returns the 35-byte telemetry frame one byte per request, header
// first; last_byte marks the checksum byte. The APB port sets the segment and
// the six reciprocal scales; write it only while no frame is in flight.
// The first frame byte is valid once the sequencer enters its emit state and
// loads it into the output register. With an always-ready receiver, one byte
// a cycle leaves that register; the next record is taken in the same cycle
// as the checksum byte is loaded. Each value goes through a shared 32x32
// multiplier and a rounding stage, one value per cycle, well ahead of its
// bytes. A receiver stall holds the output register and the byte sequencer;
// no byte is dropped or repeated, and rec_i.ready stays low until the frame's
// last byte is loaded. Reset empties the output register, returns the
// sequencer to idle and loads the register reset values (orbit segment).
module nav_state_frame_serializer import nsfs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  nsfs_rec_if.sink              rec_i,
  nsfs_frame_if.source          frame_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t                        cfg;
  ctrl_cmd_t                   cmd;
  dp_status_t                  sts;
  logic [NUM_FIELDS-1:0][31:0] rec_vals;

  // record fields in frame order
  assign rec_vals[0]  = rec_i.pos_x;
  assign rec_vals[1]  = rec_i.pos_y;
  assign rec_vals[2]  = rec_i.pos_z;
  assign rec_vals[3]  = rec_i.vel_x;
  assign rec_vals[4]  = rec_i.vel_y;
  assign rec_vals[5]  = rec_i.vel_z;
  assign rec_vals[6]  = rec_i.angle_one;
  assign rec_vals[7]  = rec_i.angle_two;
  assign rec_vals[8]  = rec_i.angle_three;
  assign rec_vals[9]  = rec_i.rate_one;
  assign rec_vals[10] = rec_i.rate_two;
  assign rec_vals[11] = rec_i.rate_three;

  nsfs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  nsfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rec_i.valid),
    .in_ready_o (rec_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nsfs_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .rec_vals_i   (rec_vals),
    .out_valid_o  (frame_o.valid),
    .out_ready_i  (frame_o.ready),
    .frame_byte_o (frame_o.frame_byte),
    .last_byte_o  (frame_o.last_byte)
  );

endmodule

/* rtl/core/nsfs_checker.sv */
// port-level checks of the serializer and their binding to the top level
`include "nav_state_frame_serializer_macros.svh"

module nsfs_checker import nsfs_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] frame_byte_i,
  input logic       last_byte_i
);

  logic              in_acc;
  logic              out_acc;
  logic              frame_done;
  logic [BIDX_W-1:0] cnt_q;
  logic [1:0]        pend_q;

  assign in_acc     = in_valid_i && in_ready_i;
  assign out_acc    = out_valid_i && out_ready_i;
  assign frame_done = out_acc && last_byte_i;

  // byte position in the frame and records taken but not fully delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pend_q <= '0;
    end else begin
      if (out_acc) begin
        cnt_q <= last_byte_i ? '0 : cnt_q + BIDX_W'(1);
      end
      pend_q <= pend_q + 2'(in_acc) - 2'(frame_done);
    end
  end

  `NSFS_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(frame_byte_i) && $stable(last_byte_i), "stalled frame byte changed")
  `NSFS_ASSERT_IMP(a_last_pos, out_acc, last_byte_i == (cnt_q == LAST_IDX), "last byte flag at wrong position")
  `NSFS_ASSERT_IMP(a_header, out_acc && (cnt_q == BYTE_HDR), frame_byte_i == HDR_BYTE, "frame does not open with the header byte")
  `NSFS_ASSERT_IMP(a_one_ahead, in_acc, pend_q <= 2'd1, "record taken with two frames outstanding")
  `NSFS_ASSERT_IMP(a_no_orphan, out_valid_i, pend_q != 2'd0, "frame byte shown with no record taken")

endmodule

bind nav_state_frame_serializer nsfs_checker u_nsfs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (rec_i.valid),
  .in_ready_i   (rec_i.ready),
  .out_valid_i  (frame_o.valid),
  .out_ready_i  (frame_o.ready),
  .frame_byte_i (frame_o.frame_byte),
  .last_byte_i  (frame_o.last_byte)
);
